### src/lvcq_pkg.sv
// ----------------------------------------------------------------------------
// lvcq_pkg
// Shared types and constants for the latest value command queue.
// ----------------------------------------------------------------------------
package lvcq_pkg;

  // Field widths of the request and response channels
  localparam int FIELD_W     = 64;
  localparam int CMD_W       = 2;
  localparam int COUNT_OUT_W = 4;

  // Default sizing of the queue
  localparam int QUEUE_DEPTH_DEF   = 12;
  localparam int KEY_BYTES_DEF     = 8;
  localparam int PAYLOAD_BYTES_DEF = 8;

  // Command codes; the fourth code is unused and leaves the queue alone
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_POP     = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_HEAD_RD,
    S_HEAD_CAP
  } state_t;

endpackage

### src/lvcq_if.sv
// ----------------------------------------------------------------------------
// lvcq_req_if / lvcq_rsp_if
// Valid/ready channels carrying queue commands and queue status.
// ----------------------------------------------------------------------------

// Command request channel
interface lvcq_req_if import lvcq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [FIELD_W-1:0] key_word;
  logic [FIELD_W-1:0] payload_word;

  modport source (output valid, command, key_word, payload_word, input ready);
  modport sink   (input valid, command, key_word, payload_word, output ready);
endinterface

// Status response channel
interface lvcq_rsp_if import lvcq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic                   head_valid;
  logic [FIELD_W-1:0]     head_key;
  logic [FIELD_W-1:0]     head_payload;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, accepted, head_valid, head_key, head_payload, entry_count,
                  input ready);
  modport sink   (input valid, accepted, head_valid, head_key, head_payload, entry_count,
                  output ready);
endinterface

### src/latest_value_command_queue_unit.sv
// ----------------------------------------------------------------------------
// latest_value_command_queue_unit
// FIFO of key/payload pairs that keeps only the newest command per key.
// ----------------------------------------------------------------------------
// Each request (enqueue, pop or clear) returns one response with the accept
// flag, the head entry and the entry count after the command. Requests are
// taken one at a time. An enqueue on a non-empty queue walks the queued entries
// through a slot memory with one read and one write port, one slot per cycle,
// dropping those whose key matches and rewriting survivors in order. It then
// appends the new entry, reads the head and captures the response. An enqueue
// on an empty queue skips the scan, and a pop, a clear or the unused code goes
// straight to the head read and capture. The response is registered as the
// block returns to idle and is ready again. A stalled response holds the block
// in its last step. Only the low KEY_BYTES and PAYLOAD_BYTES bytes of the words
// are stored and compared; an empty queue reports a zero head. A new request is
// taken while the previous response still waits in the output register.

module latest_value_command_queue_unit import lvcq_pkg::*; #(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int KEY_BYTES     = KEY_BYTES_DEF,
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic   clk,
  input  logic   rst,
  lvcq_req_if.sink   req,
  lvcq_rsp_if.source rsp
);

  localparam int KW = KEY_BYTES * 8;
  localparam int VW = PAYLOAD_BYTES * 8;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW:0]   DEPTH_X = (CW+1)'(QUEUE_DEPTH);

  // Ring pointer advance
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_C) ? '0 : p + 1'b1;
  endfunction

  state_t state, state_next;

  logic [CMD_W-1:0] cmd_reg;
  logic [KW-1:0]    key_reg;
  logic [VW-1:0]    pay_reg;
  logic [PW-1:0]    head;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    kept;
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr;
  logic             acc;

  // Slot memory
  logic [KW-1:0] key_mem [QUEUE_DEPTH];
  logic [VW-1:0] pay_mem [QUEUE_DEPTH];
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_pay;

  logic [PW-1:0] rd_addr;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [KW-1:0] wr_key;
  logic [VW-1:0] wr_pay;
  logic          keep_hit;
  logic          room;
  logic          cap;
  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_wrap;
  logic [PW-1:0] tail;

  logic [CW+COUNT_OUT_W-1:0] count_ext;
  logic [KW+FIELD_W-1:0]     key_ext;
  logic [VW+FIELD_W-1:0]     pay_ext;

  // Tail slot: head + count modulo depth
  assign tail_sum  = (CW+1)'(head) + (CW+1)'(count);
  assign tail_wrap = (tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum;
  assign tail      = tail_wrap[PW-1:0];
  assign room      = (count < DEPTH_C);

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};
  assign key_ext   = {{FIELD_W{1'b0}}, rd_key};
  assign pay_ext   = {{FIELD_W{1'b0}}, rd_pay};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.command == CMD_ENQUEUE) begin
            state_next = (count == '0) ? S_APPEND : S_SCAN;
          end else begin
            state_next = S_HEAD_RD;
          end
        end
      end
      S_SCAN: begin
        if (idx == count) state_next = S_APPEND;
      end
      S_APPEND:   state_next = S_HEAD_RD;
      S_HEAD_RD:  state_next = S_HEAD_CAP;
      S_HEAD_CAP: begin
        if (cap) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: memory port control
  always_comb begin
    req.ready = (state == S_IDLE);
    rd_addr   = head;
    wr_en     = 1'b0;
    wr_addr   = wr_ptr;
    wr_key    = rd_key;
    wr_pay    = rd_pay;
    keep_hit  = 1'b0;
    cap       = 1'b0;
    unique case (state)
      S_SCAN: begin
        if (idx < count) rd_addr = rd_ptr;
        // compare the slot read last cycle; survivors move up to the write pointer
        if (idx != '0 && rd_key != key_reg) begin
          keep_hit = 1'b1;
          wr_en    = 1'b1;
        end
      end
      S_APPEND: begin
        if (room) begin
          wr_en   = 1'b1;
          wr_addr = tail;
          wr_key  = key_reg;
          wr_pay  = pay_reg;
        end
      end
      S_HEAD_CAP: cap = !rsp.valid || rsp.ready;
      default: ;
    endcase
  end

  // Slot memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    rd_key <= key_mem[rd_addr];
    rd_pay <= pay_mem[rd_addr];
  end

  // Control and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      acc       <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_reg <= req.command;
            key_reg <= req.key_word[KW-1:0];
            pay_reg <= req.payload_word[VW-1:0];
            acc     <= 1'b0;
            idx     <= '0;
            kept    <= '0;
            rd_ptr  <= head;
            wr_ptr  <= head;
            case (req.command)
              CMD_POP: begin
                if (count != '0) begin
                  head  <= ptr_inc(head);
                  count <= count - 1'b1;
                end
              end
              CMD_CLEAR: begin
                head  <= '0;
                count <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (idx < count) begin
            rd_ptr <= ptr_inc(rd_ptr);
            idx    <= idx + 1'b1;
          end
          if (keep_hit) begin
            wr_ptr <= ptr_inc(wr_ptr);
            kept   <= kept + 1'b1;
          end
          if (idx == count) count <= kept + CW'(keep_hit);
        end
        S_APPEND: begin
          if (room) begin
            count <= count + 1'b1;
            acc   <= 1'b1;
          end
        end
        default: ;
      endcase

      // Response register
      if (cap) begin
        rsp.valid        <= 1'b1;
        rsp.accepted     <= acc;
        rsp.head_valid   <= (count != '0);
        rsp.head_key     <= (count != '0) ? key_ext[FIELD_W-1:0] : '0;
        rsp.head_payload <= (count != '0) ? pay_ext[FIELD_W-1:0] : '0;
        rsp.entry_count  <= count_ext[COUNT_OUT_W-1:0];
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("entry count beyond queue depth");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> kept <= idx)
    else $error("compaction wrote ahead of the scan");

  a_acc_enqueue: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND && room |=> acc && cmd_reg == CMD_ENQUEUE)
    else $error("append without an enqueue request");

  a_acc_head: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.accepted |-> rsp.head_valid)
    else $error("accepted enqueue left the queue empty");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) && !rsp.head_valid |-> rsp.head_key == '0 && rsp.head_payload == '0)
    else $error("empty queue reported a non-zero head");

endmodule
